// ----- src/abmg_pkg.sv -----
`default_nettype none

package abmg_pkg;

	localparam int MAX_VERTICES_DEF = 32;

	// neighbour listing never gives more results than this for one request
	localparam int RESULT_CAP = 32;
	localparam int CAP_W = $clog2(RESULT_CAP + 1);

	localparam logic [2:0] FN_RESTART  = 3'd0;
	localparam logic [2:0] FN_ADD_EDGE = 3'd1;
	localparam logic [2:0] FN_REM_EDGE = 3'd2;
	localparam logic [2:0] FN_HAS_EDGE = 3'd3;
	localparam logic [2:0] FN_ADD_VERT = 3'd4;
	localparam logic [2:0] FN_REM_VERT = 3'd5;
	localparam logic [2:0] FN_NEIGHBRS = 3'd6;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VERT = 2'd1;

	typedef enum logic [1:0] {
		ROP_KEEP,
		ROP_SET,
		ROP_CLR,
		ROP_SQUEEZE
	} row_op_t;

endpackage

`default_nettype wire

// ----- src/abmg_row_mem.sv -----
`default_nettype none

module abmg_row_mem
	import abmg_pkg::*;
#(
	parameter int W = MAX_VERTICES_DEF,
	parameter int DEPTH = MAX_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0]     mem [DEPTH];
	logic [W-1:0]     data_q;
	logic             rvld_q;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			data_q <= mem[raddr];
		end
	end

	// a row never written since the last clear reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? data_q : '0;

endmodule

`default_nettype wire

// ----- src/abmg_row_alu.sv -----
`default_nettype none

module abmg_row_alu
	import abmg_pkg::*;
#(
	parameter int W = MAX_VERTICES_DEF
) (
	input  row_op_t              op,
	input  logic [$clog2(W)-1:0] col,
	input  logic [W-1:0]         row,
	output logic [W-1:0]         row_out,
	output logic                 bit_out,
	output logic [$clog2(W+1)-1:0] ones
);

	localparam int L  = $clog2(W);
	localparam int P  = 1 << L;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] onehot;
	logic [W-1:0] lo_mask;

	function automatic logic [CW-1:0] popcount(input logic [W-1:0] r);
		logic [P-1:0]  rp;
		logic [CW-1:0] c [P];
		rp = P'(r);
		for (int j = 0; j < P; j++) begin
			c[j] = CW'(rp[j]);
		end
		// adder tree, one level per pass
		for (int l = 0; l < L; l++) begin
			for (int j = 0; j < (P >> (l + 1)); j++) begin
				c[j] = c[2*j] + c[2*j+1];
			end
		end
		return c[0];
	endfunction

	assign onehot  = W'(1) << col;
	assign lo_mask = onehot - W'(1);
	assign bit_out = row[col];
	assign ones    = popcount(row);

	always_comb begin
		case (op)
			ROP_SET:     row_out = row | onehot;
			ROP_CLR:     row_out = row & ~onehot;
			// drop column col and pull the higher columns down by one
			ROP_SQUEEZE: row_out = (row & lo_mask) | ((row >> 1) & ~lo_mask);
			ROP_KEEP:    row_out = row;
			default:     row_out = row;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/adjacency_bit_matrix_graph_unit.sv -----
`default_nettype none

// Restart, add vertex, error and unused codes go from idle to the finish state; edge add,
// remove and query pass the edge state first (and the mirror state for a changed bit in
// undirected mode). Remove vertex makes one row memory port pass over every row. Neighbour
// listing scans one column per cycle, holding on a hit while the output stalls, up to the
// last neighbour. One request at a time; in_stall is low only while idle. Asynchronous
// reset clears the matrix (row valid bits), both counts and both configuration registers.
module adjacency_bit_matrix_graph_unit
	import abmg_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           func,
	input  logic [4:0]           src,
	input  logic [4:0]           dst,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 edge_present,
	output logic [4:0]           neighbor,
	output logic                 neighbor_valid,
	output logic                 last,
	output logic [5:0]           vertex_total,
	output logic [10:0]          edge_total
);

	localparam int W  = MAX_VERTICES;
	localparam int RW = $clog2(W);
	localparam int VW = $clog2(W + 1);
	localparam int NW = $clog2(2 * W);
	localparam int EW = $clog2(W * W + 1) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MIRROR,
		ST_RV_HEAD,
		ST_SWEEP,
		ST_NB_HEAD,
		ST_NB_SCAN,
		ST_FINISH
	} state_t;

	state_t         state_q;
	logic           dir_q;
	logic [5:0]     init_q;
	logic [VW-1:0]  vc_q;
	logic [EW-1:0]  ec_q;
	logic [2:0]     func_q;
	logic [RW-1:0]  src_q;
	logic [RW-1:0]  dst_q;
	logic [1:0]     sts_q;
	logic           present_q;
	logic [NW-1:0]  n_q;
	logic [VW-1:0]  ri_q;
	logic [RW-1:0]  tgt_s1;
	logic [VW-1:0]  j_s1;
	logic           zero_s1;
	logic [W-1:0]   row_q;
	logic [CAP_W-1:0] total_q;
	logic [CAP_W-1:0] k_q;
	logic [RW-1:0]  scan_q;

	logic           out_valid_q;
	logic [1:0]     out_status_q;
	logic           out_present_q;
	logic [4:0]     out_nb_q;
	logic           out_nbv_q;
	logic           out_last_q;
	logic [5:0]     out_vt_q;
	logic [10:0]    out_et_q;

	logic           accept;
	logic           s_ok;
	logic           d_ok;
	logic           out_free;
	logic           out_load;
	logic           mem_clr;
	logic           mem_we;
	logic           mem_re;
	logic [RW-1:0]  mem_waddr;
	logic [RW-1:0]  mem_raddr;
	logic [W-1:0]   mem_wdata;
	logic [W-1:0]   rd_data;
	row_op_t        alu_op;
	logic [RW-1:0]  alu_col;
	logic [W-1:0]   alu_row;
	logic [W-1:0]   alu_out;
	logic           alu_bit;
	logic [VW-1:0]  alu_ones;
	logic [VW-1:0]  j0;
	logic [VW-1:0]  nxt_j;
	logic           col_hit;
	logic [NW-1:0]  n_nxt;

	abmg_row_mem #(
		.W     (W),
		.DEPTH (W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (rd_data)
	);

	abmg_row_alu #(
		.W (W)
	) u_alu (
		.op      (alu_op),
		.col     (alu_col),
		.row     (alu_row),
		.row_out (alu_out),
		.bit_out (alu_bit),
		.ones    (alu_ones)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign s_ok      = int'(src) < int'(vc_q);
	assign d_ok      = int'(dst) < int'(vc_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == ST_FINISH) ||
	                                ((state_q == ST_NB_SCAN) && alu_bit));

	// source row for a sweep target: rows below the removed vertex stay, the rest move down
	assign j0    = (src_q == '0) ? VW'(1) : '0;
	assign nxt_j = (ri_q < VW'(src_q)) ? ri_q : ri_q + VW'(1);

	assign col_hit = dir_q && !zero_s1 && (j_s1 != VW'(src_q)) && (j_s1 < vc_q) && alu_bit;
	assign n_nxt   = n_q + {{(NW-1){1'b0}}, col_hit};

	always_comb begin
		mem_clr   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = src_q;
		mem_raddr = src_q;
		alu_op    = ROP_KEEP;
		alu_col   = dst_q;
		alu_row   = rd_data;
		case (state_q)
			ST_IDLE: begin
				mem_clr   = accept && (func == FN_RESTART);
				mem_re    = accept;
				mem_raddr = RW'(src);
			end
			ST_EDGE: begin
				alu_op    = (func_q == FN_ADD_EDGE) ? ROP_SET : ROP_CLR;
				mem_we    = ((func_q == FN_ADD_EDGE) && !alu_bit) ||
				            ((func_q == FN_REM_EDGE) && alu_bit);
				mem_re    = mem_we && !dir_q;
				mem_raddr = dst_q;
			end
			ST_MIRROR: begin
				alu_op    = (func_q == FN_ADD_EDGE) ? ROP_SET : ROP_CLR;
				alu_col   = src_q;
				mem_we    = 1'b1;
				mem_waddr = dst_q;
			end
			ST_RV_HEAD: begin
				mem_re    = 1'b1;
				mem_raddr = RW'(j0);
			end
			ST_SWEEP: begin
				alu_op    = ROP_SQUEEZE;
				alu_col   = src_q;
				alu_row   = zero_s1 ? '0 : rd_data;
				mem_we    = 1'b1;
				mem_waddr = tgt_s1;
				mem_re    = (ri_q < VW'(W)) && (nxt_j < VW'(W));
				mem_raddr = RW'(nxt_j);
			end
			ST_NB_SCAN: begin
				alu_row = row_q;
				alu_col = scan_q;
			end
			default: begin
				alu_op = ROP_KEEP;
			end
		endcase
		mem_wdata = alu_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			dir_q         <= 1'b0;
			init_q        <= '0;
			vc_q          <= '0;
			ec_q          <= '0;
			func_q        <= FN_RESTART;
			src_q         <= '0;
			dst_q         <= '0;
			sts_q         <= STS_OK;
			present_q     <= 1'b0;
			n_q           <= '0;
			ri_q          <= '0;
			tgt_s1        <= '0;
			j_s1          <= '0;
			zero_s1       <= 1'b0;
			row_q         <= '0;
			total_q       <= '0;
			k_q           <= '0;
			scan_q        <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= STS_OK;
			out_present_q <= 1'b0;
			out_nb_q      <= '0;
			out_nbv_q     <= 1'b0;
			out_last_q    <= 1'b0;
			out_vt_q      <= '0;
			out_et_q      <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_DIRECTED) begin
					dir_q <= cfg_data[0];
				end else if (cfg_index == CFG_INIT_VERT) begin
					init_q <= cfg_data;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q    <= func;
						src_q     <= RW'(src);
						dst_q     <= RW'(dst);
						present_q <= 1'b0;
						case (func)
							FN_RESTART: begin
								vc_q    <= (int'(init_q) > W) ? VW'(W) : VW'(init_q);
								ec_q    <= '0;
								sts_q   <= STS_OK;
								state_q <= ST_FINISH;
							end
							FN_ADD_EDGE, FN_REM_EDGE, FN_HAS_EDGE: begin
								if (s_ok && d_ok) begin
									sts_q   <= STS_OK;
									state_q <= ST_EDGE;
								end else begin
									sts_q   <= STS_RANGE;
									state_q <= ST_FINISH;
								end
							end
							FN_ADD_VERT: begin
								if (int'(vc_q) >= W) begin
									sts_q <= STS_FULL;
								end else begin
									vc_q  <= vc_q + VW'(1);
									sts_q <= STS_OK;
								end
								state_q <= ST_FINISH;
							end
							FN_REM_VERT: begin
								if (s_ok) begin
									sts_q   <= STS_OK;
									state_q <= ST_RV_HEAD;
								end else begin
									sts_q   <= STS_RANGE;
									state_q <= ST_FINISH;
								end
							end
							FN_NEIGHBRS: begin
								if (s_ok) begin
									sts_q   <= STS_OK;
									state_q <= ST_NB_HEAD;
								end else begin
									sts_q   <= STS_RANGE;
									state_q <= ST_FINISH;
								end
							end
							default: begin
								sts_q   <= STS_OK;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_EDGE: begin
					if (func_q == FN_HAS_EDGE) begin
						present_q <= alu_bit;
					end
					if ((func_q == FN_ADD_EDGE) && !alu_bit) begin
						ec_q <= ec_q + EW'(1);
					end else if ((func_q == FN_REM_EDGE) && alu_bit) begin
						ec_q <= (ec_q == '0) ? '0 : ec_q - EW'(1);
					end
					state_q <= (mem_we && !dir_q) ? ST_MIRROR : ST_FINISH;
				end
				ST_MIRROR: begin
					state_q <= ST_FINISH;
				end
				ST_RV_HEAD: begin
					// whole row of the removed vertex, self-loop included
					n_q     <= NW'(alu_ones);
					tgt_s1  <= '0;
					j_s1    <= j0;
					zero_s1 <= 1'b0;
					ri_q    <= VW'(1);
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (ri_q < VW'(W)) begin
						n_q     <= n_nxt;
						tgt_s1  <= RW'(ri_q);
						j_s1    <= nxt_j;
						zero_s1 <= (nxt_j >= VW'(W));
						ri_q    <= ri_q + VW'(1);
					end else begin
						ec_q    <= (EW'(n_nxt) >= ec_q) ? '0 : ec_q - EW'(n_nxt);
						vc_q    <= vc_q - VW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_NB_HEAD: begin
					row_q   <= rd_data;
					total_q <= (int'(alu_ones) > RESULT_CAP) ? CAP_W'(RESULT_CAP)
					                                         : CAP_W'(alu_ones);
					k_q     <= '0;
					scan_q  <= '0;
					state_q <= (alu_ones == '0) ? ST_FINISH : ST_NB_SCAN;
				end
				ST_NB_SCAN: begin
					if (!alu_bit) begin
						scan_q <= scan_q + RW'(1);
					end else if (out_free) begin
						out_status_q  <= STS_OK;
						out_present_q <= 1'b0;
						out_nb_q      <= 5'(scan_q);
						out_nbv_q     <= 1'b1;
						out_last_q    <= (k_q + CAP_W'(1)) == total_q;
						out_vt_q      <= 6'(vc_q);
						out_et_q      <= 11'(ec_q);
						k_q           <= k_q + CAP_W'(1);
						scan_q        <= scan_q + RW'(1);
						if ((k_q + CAP_W'(1)) == total_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_status_q  <= sts_q;
						out_present_q <= present_q;
						out_nb_q      <= '0;
						out_nbv_q     <= 1'b0;
						out_last_q    <= 1'b1;
						out_vt_q      <= 6'(vc_q);
						out_et_q      <= 11'(ec_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign edge_present   = out_present_q;
	assign neighbor       = out_nb_q;
	assign neighbor_valid = out_nbv_q;
	assign last           = out_last_q;
	assign vertex_total   = out_vt_q;
	assign edge_total     = out_et_q;

`ifndef SYNTHESIS
	a_vc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(vc_q) <= W)
		else $error("vertex count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("row write while idle");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FN_RESTART)) |=> (ec_q == '0))
		else $error("restart left edges counted");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB_SCAN) |-> (k_q < total_q))
		else $error("neighbour scan ran past its result count");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (int'(ri_q) <= W))
		else $error("row sweep pointer overran");
`endif

endmodule

`default_nettype wire
